FILE: hdl/positional_ordered_list_core_macros.svh
// Assertion macros for the positional ordered list core.
// Used by positional_ordered_list_core.sv; expects clk and rst_n in scope.
`ifndef POSITIONAL_ORDERED_LIST_CORE_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define POLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define POLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/polc_pkg.sv
// Shared types and codes for the positional ordered list core.
// No dependencies; used by polc_cell and positional_ordered_list_core.
package polc_pkg;

  // Index width wide enough for any supported capacity (up to 31, set by the 5-bit position and length fields) plus one
  localparam int unsigned IDX_W = 7;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Per-cycle command broadcast to the cell chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [IDX_W-1:0]   pos_m1;  // zero-based target position
    logic [IDX_W-1:0]   cnt;     // current list length
  } cell_ctrl_t;

  // Input word
  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         list_length;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic signed [31:0] dump_value;
    logic               last;
  } out_word_t;

endpackage

FILE: hdl/polc_cell.sv
// One storage cell of the list chain: holds one entry and shifts with neighbors.
// Depends on polc_pkg for the control struct.
module polc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                    clk,
  input  polc_pkg::cell_ctrl_t    ctrl,
  input  logic signed [31:0]      new_val,
  input  logic signed [31:0]      left_val,
  input  logic signed [31:0]      right_val,
  input  logic signed [31:0]      head_val,
  output logic signed [31:0]      val_r
);

  localparam logic [polc_pkg::IDX_W-1:0] MY_IDX  = polc_pkg::IDX_W'(IDX);
  localparam logic [polc_pkg::IDX_W-1:0] MY_NEXT = polc_pkg::IDX_W'(IDX + 1);

  logic signed [31:0] val_nxt;

  // Local decision from own index against the broadcast position and length
  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.cmd)
      polc_pkg::CELL_INSERT: begin
        if (MY_IDX == ctrl.pos_m1) val_nxt = new_val;
        else if (MY_IDX > ctrl.pos_m1) val_nxt = left_val;
      end
      polc_pkg::CELL_DELETE: begin
        if (MY_IDX >= ctrl.pos_m1) val_nxt = right_val;
      end
      polc_pkg::CELL_ROTATE: begin
        // tail cell wraps the head around; cells before it move down
        if (MY_NEXT == ctrl.cnt) val_nxt = head_val;
        else if (MY_NEXT < ctrl.cnt) val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: hdl/positional_ordered_list_core.sv
// Positional ordered list core: a chain of CAPACITY cells, one entry each.
// Insert/delete/invalid: one result in the cycle after acceptance; busy stays low.
// Dump of n entries: busy while the dump runs, n results in list order from the head.
// Throughput: one insert/delete per cycle; a dump holds the chain until its last entry is shown.
// The receiver cannot stall: each result is shown for one cycle with out_valid.
// Synchronous active-low reset empties the list; entry storage is not cleared.
`include "positional_ordered_list_core_macros.svh"

module positional_ordered_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  polc_pkg::in_word_t    in_word,
  output logic                  out_valid,
  output polc_pkg::out_word_t   out_word
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IW    = polc_pkg::IDX_W;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     dump_idx_r, dump_idx_nxt;
  logic                 dump_active_r, dump_active_nxt;
  logic                 rep_r, rep_nxt;
  logic [1:0]           status_r, status_nxt;
  logic signed [31:0]   head_snap_r, head_snap_nxt;
  logic signed [31:0]   tail_snap_r, tail_snap_nxt;

  logic                 acc;
  logic                 acc_single;
  logic [IW-1:0]        cnt_ext;
  logic [IW-1:0]        pos_ext;
  logic signed [31:0]   tail_sel;
  polc_pkg::cell_ctrl_t ctrl;
  logic signed [31:0]   cell_val [CAPACITY];

  assign acc     = start && !busy;
  assign busy    = dump_active_r;
  assign cnt_ext = IW'(count_r);
  assign pos_ext = IW'(in_word.position);

  // Accepted word that answers with a single result
  assign acc_single = acc && !(in_word.req_type == polc_pkg::REQ_DUMP && count_r != '0);

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = in_word.item_value;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end
    polc_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_val   (in_word.item_value),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .val_r     (cell_val[i])
    );
  end

  // Tail pick: one-hot AND-OR over the cells, the tail cell matches the length
  always_comb begin
    tail_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cnt_ext == IW'(i + 1)) tail_sel = tail_sel | cell_val[i];
    end
  end

  // Request decode and next-state
  always_comb begin
    ctrl.cmd        = polc_pkg::CELL_HOLD;
    ctrl.pos_m1     = pos_ext - IW'(1);
    ctrl.cnt        = cnt_ext;
    count_nxt       = count_r;
    dump_idx_nxt    = dump_idx_r;
    dump_active_nxt = dump_active_r;
    rep_nxt         = 1'b0;
    status_nxt      = status_r;
    head_snap_nxt   = head_snap_r;
    tail_snap_nxt   = tail_snap_r;

    if (dump_active_r) begin
      // rotate one step per cycle; after count steps the order is restored
      ctrl.cmd     = polc_pkg::CELL_ROTATE;
      dump_idx_nxt = dump_idx_r + CNT_W'(1);
      if ((dump_idx_r + CNT_W'(1)) == count_r) dump_active_nxt = 1'b0;
    end else if (acc) begin
      rep_nxt = 1'b1;
      case (in_word.req_type)
        polc_pkg::REQ_INSERT: begin
          if (cnt_ext >= IW'(CAPACITY)) begin
            status_nxt = polc_pkg::ST_FULL;
          end else if (pos_ext == '0 || pos_ext > cnt_ext + IW'(1)) begin
            status_nxt = polc_pkg::ST_INVALID;
          end else begin
            status_nxt = polc_pkg::ST_OK;
            ctrl.cmd   = polc_pkg::CELL_INSERT;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        polc_pkg::REQ_DELETE: begin
          if (count_r == '0) begin
            status_nxt = polc_pkg::ST_EMPTY;
          end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
            status_nxt = polc_pkg::ST_INVALID;
          end else begin
            status_nxt = polc_pkg::ST_OK;
            ctrl.cmd   = polc_pkg::CELL_DELETE;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        polc_pkg::REQ_DUMP: begin
          if (count_r == '0) begin
            status_nxt = polc_pkg::ST_EMPTY;
          end else begin
            rep_nxt         = 1'b0;
            dump_active_nxt = 1'b1;
            dump_idx_nxt    = '0;
            head_snap_nxt   = cell_val[0];
            tail_snap_nxt   = tail_sel;
          end
        end
        default: status_nxt = polc_pkg::ST_INVALID;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      dump_active_r <= 1'b0;
      rep_r         <= 1'b0;
      dump_idx_r    <= '0;
    end else begin
      count_r       <= count_nxt;
      dump_active_r <= dump_active_nxt;
      rep_r         <= rep_nxt;
      dump_idx_r    <= dump_idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    head_snap_r <= head_snap_nxt;
    tail_snap_r <= tail_snap_nxt;
  end

  // Result word: report after each single-result request, or one entry per dump cycle
  always_comb begin
    out_valid            = rep_r || dump_active_r;
    out_word.list_length = 5'(count_r);
    if (dump_active_r) begin
      out_word.status     = polc_pkg::ST_OK;
      out_word.head_value = head_snap_r;
      out_word.tail_value = tail_snap_r;
      out_word.dump_value = cell_val[0];
      out_word.last       = ((dump_idx_r + CNT_W'(1)) == count_r);
    end else begin
      out_word.status     = status_r;
      out_word.head_value = (count_r != '0) ? cell_val[0] : '0;
      out_word.tail_value = (count_r != '0) ? tail_sel : '0;
      out_word.dump_value = '0;
      out_word.last       = 1'b1;
    end
  end

  // Assertions
  `POLC_ASSERT_NOW(a_count_bound, 1'b1, cnt_ext <= IW'(CAPACITY), "list length above capacity")
  `POLC_ASSERT_NEXT(a_single_report, acc_single, out_valid && out_word.last, "missing result")
  `POLC_ASSERT_NEXT(a_dump_count_stable, dump_active_r, $stable(count_r), "length moved in dump")
  `POLC_ASSERT_NOW(a_dump_idx_range, dump_active_r, dump_idx_r < count_r, "dump index past end")
  `POLC_ASSERT_NOW(a_no_overlap, 1'b1, !(rep_r && dump_active_r), "report and dump overlap")

endmodule

FILE: tb/ordered_list_checker.sv
`timescale 1ns / 100ps
// Result checker for the positional ordered list core: keeps a shadow copy
// of the list, predicts every result word and compares it with the core.
// Depends on polc_pkg.
module ordered_list_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  polc_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  polc_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  pending,
  output int                  cur_len
);

  // Shadow list, head at index 0
  logic signed [31:0]  shadow_vals [CAPACITY];
  int                  shadow_len = 0;
  polc_pkg::out_word_t expected_words [$];
  polc_pkg::out_word_t want;

  // Build one result word from the current shadow list
  function automatic polc_pkg::out_word_t list_word(input logic [1:0] st,
                                                    input logic signed [31:0] dv,
                                                    input logic lst);
    polc_pkg::out_word_t w;
    w.status      = st;
    w.list_length = shadow_len[4:0];
    w.head_value  = (shadow_len > 0) ? shadow_vals[0] : 32'sd0;
    w.tail_value  = (shadow_len > 0) ? shadow_vals[shadow_len - 1] : 32'sd0;
    w.dump_value  = dv;
    w.last        = lst;
    return w;
  endfunction

  // Apply one accepted word to the shadow list and queue its results
  task automatic apply_request(input polc_pkg::in_word_t w);
    int p;
    p = int'(w.position);
    case (w.req_type)
      polc_pkg::REQ_INSERT: begin
        // full check wins over the position check
        if (shadow_len >= CAPACITY) begin
          expected_words.push_back(list_word(polc_pkg::ST_FULL, 32'sd0, 1'b1));
        end else if (p == 0 || p > shadow_len + 1) begin
          expected_words.push_back(list_word(polc_pkg::ST_INVALID, 32'sd0, 1'b1));
        end else begin
          for (int i = shadow_len; i >= p; i--) shadow_vals[i] = shadow_vals[i - 1];
          shadow_vals[p - 1] = w.item_value;
          shadow_len++;
          expected_words.push_back(list_word(polc_pkg::ST_OK, 32'sd0, 1'b1));
        end
      end
      polc_pkg::REQ_DELETE: begin
        // empty check wins over the position check
        if (shadow_len == 0) begin
          expected_words.push_back(list_word(polc_pkg::ST_EMPTY, 32'sd0, 1'b1));
        end else if (p == 0 || p > shadow_len) begin
          expected_words.push_back(list_word(polc_pkg::ST_INVALID, 32'sd0, 1'b1));
        end else begin
          for (int i = p; i < shadow_len; i++) shadow_vals[i - 1] = shadow_vals[i];
          shadow_len--;
          expected_words.push_back(list_word(polc_pkg::ST_OK, 32'sd0, 1'b1));
        end
      end
      polc_pkg::REQ_DUMP: begin
        if (shadow_len == 0) begin
          expected_words.push_back(list_word(polc_pkg::ST_EMPTY, 32'sd0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_len; i++)
            expected_words.push_back(list_word(polc_pkg::ST_OK, shadow_vals[i],
                                               (i == shadow_len - 1)));
        end
      end
      default: begin
        // unused request code: one invalid word, list untouched
        expected_words.push_back(list_word(polc_pkg::ST_INVALID, 32'sd0, 1'b1));
      end
    endcase
  endtask

  // Predict on acceptance, then check any result word at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_len = 0;
      fail_count = 0;
    end else begin
      if (start && !busy) apply_request(in_word);
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result word: st=%0d len=%0d head=%0d",
                     $realtime, out_word.status, out_word.list_length,
                     out_word.head_value, " tail=%0d dump=%0d last=%0b",
                     out_word.tail_value, out_word.dump_value, out_word.last);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_word.status !== want.status || out_word.list_length !== want.list_length ||
              out_word.head_value !== want.head_value ||
              out_word.tail_value !== want.tail_value ||
              out_word.dump_value !== want.dump_value || out_word.last !== want.last) begin
            if (fail_count < 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  want: st=%0d len=%0d head=%0d tail=%0d dump=%0d last=%0b",
                       want.status, want.list_length, want.head_value,
                       want.tail_value, want.dump_value, want.last);
              $display("  got:  st=%0d len=%0d head=%0d tail=%0d dump=%0d last=%0b",
                       out_word.status, out_word.list_length, out_word.head_value,
                       out_word.tail_value, out_word.dump_value, out_word.last);
            end
            fail_count++;
          end
        end
      end
    end
    pending = expected_words.size();
    cur_len = shadow_len;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the positional ordered list core: clock, reset, request
// stimulus and verdict. Depends on polc_pkg and ordered_list_checker.
module testbench;

  localparam int unsigned LIST_CAP     = 16;
  localparam int          RANDOM_WORDS = 200;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;

  typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  polc_pkg::in_word_t  in_word;
  logic                out_valid;
  polc_pkg::out_word_t out_word;
  int                  fail_count;
  int                  pending;
  int                  cur_len;
  int                  cycles = 0;
  bit                  no_idle = 1'b0;
  phase_t              phase = PH_GROW;

  positional_ordered_list_core #(.CAPACITY(LIST_CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  ordered_list_checker #(.CAPACITY(LIST_CAP)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending),
    .cur_len    (cur_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic polc_pkg::in_word_t mk(input logic [1:0] req, input int pos,
                                            input logic signed [31:0] val);
    polc_pkg::in_word_t w;
    w.req_type   = req;
    w.position   = pos[4:0];
    w.item_value = val;
    return w;
  endfunction

  // Extremes, small values and full-range random values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5:    return $signed($urandom_range(0, 200)) - 32'sd100;
      default: return $signed($urandom);
    endcase
  endfunction

  // Position outside 1..max_ok
  function automatic int bad_pos(input int max_ok);
    if (max_ok >= 31 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(max_ok + 1, 31);
  endfunction

  // Mostly well-formed requests steered by phase, some noise
  function automatic polc_pkg::in_word_t make_word();
    polc_pkg::in_word_t w;
    int                 r;
    int                 ins_pct;
    int                 del_pct;
    w.item_value = pick_value();
    if ($urandom_range(0, 99) < 10) begin
      w.req_type = 2'($urandom_range(0, 3));
      w.position = 5'($urandom_range(0, 31));
      return w;
    end
    case (phase)
      PH_GROW:   begin ins_pct = 70; del_pct = 15; end
      PH_SHRINK: begin ins_pct = 20; del_pct = 65; end
      default:   begin ins_pct = 40; del_pct = 40; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      w.req_type = polc_pkg::REQ_INSERT;
      w.position = ($urandom_range(0, 9) == 0) ? 5'(bad_pos(cur_len + 1))
                                               : 5'($urandom_range(1, cur_len + 1));
    end else if (r < ins_pct + del_pct) begin
      w.req_type = polc_pkg::REQ_DELETE;
      w.position = (cur_len == 0 || $urandom_range(0, 9) == 0)
                   ? 5'(bad_pos(cur_len)) : 5'($urandom_range(1, cur_len));
    end else begin
      w.req_type = polc_pkg::REQ_DUMP;
      w.position = 5'($urandom_range(0, 31));
    end
    return w;
  endfunction

  // Present one word from a falling edge, hold it until accepted
  task automatic send_word(input polc_pkg::in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    // busy only moves at a rising edge: low here means the next edge takes the word
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    // occasional switch into or out of back-to-back bursts
    if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
  endtask

  initial begin
    start   = 1'b0;
    in_word = '0;
    rst_n   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list cases
    send_word(mk(polc_pkg::REQ_DUMP, 0, 32'sd0));
    send_word(mk(polc_pkg::REQ_DELETE, 1, 32'sd0));
    send_word(mk(polc_pkg::REQ_INSERT, 0, 32'sd5));
    send_word(mk(polc_pkg::REQ_INSERT, 2, 32'sd5));
    // head, tail and middle inserts with extreme values
    send_word(mk(polc_pkg::REQ_INSERT, 1, 32'sh7fffffff));
    send_word(mk(polc_pkg::REQ_INSERT, 2, 32'sh80000000));
    send_word(mk(polc_pkg::REQ_INSERT, 1, -32'sd1));
    send_word(mk(polc_pkg::REQ_INSERT, 2, 32'sd0));
    send_word(mk(polc_pkg::REQ_DUMP, 31, -32'sd1));
    // bad positions and the unused request code
    send_word(mk(polc_pkg::REQ_DELETE, 0, 32'sd0));
    send_word(mk(polc_pkg::REQ_DELETE, 5, 32'sd0));
    send_word(mk(REQ_UNUSED, 31, -32'sd1));
    // fill to capacity, then overflow
    while (cur_len < LIST_CAP)
      send_word(mk(polc_pkg::REQ_INSERT, cur_len + 1, pick_value()));
    send_word(mk(polc_pkg::REQ_DUMP, 0, 32'sd0));
    send_word(mk(polc_pkg::REQ_INSERT, 17, 32'sd9));
    send_word(mk(polc_pkg::REQ_DELETE, 1, 32'sd0));
    send_word(mk(polc_pkg::REQ_DELETE, LIST_CAP - 1, 32'sd0));

    // Random phases of growth, shrinkage and mixed traffic
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) phase = phase_t'($urandom_range(0, 2));
      send_word(make_word());
    end
    start <= 1'b0;

    // Drain, then a few more cycles for stray words
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/polc_pkg.sv
hdl/polc_cell.sv
hdl/positional_ordered_list_core.sv
tb/ordered_list_checker.sv
tb/testbench.sv
